// File: rtl/core/verlet_particle_step_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Verlet particle step block.
// Each macro checks one implication on the rising clock edge, outside reset.
// ---------------------------------------------------------------------------
`ifndef VERLET_PARTICLE_STEP_MACROS_SVH
`define VERLET_PARTICLE_STEP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define VPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vps assertion failed");
// Next-cycle implication.
`define VPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vps assertion failed");
`else
`define VPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/vps_pkg.sv
// ---------------------------------------------------------------------------
// Verlet particle step package
// Shared types, action codes, constants and saturation helpers.
// ---------------------------------------------------------------------------
package vps_pkg;

   localparam logic [2:0] FUNC_ADD_FORCE = 3'd0;
   localparam logic [2:0] FUNC_TICK      = 3'd1;
   localparam logic [2:0] FUNC_GROUND    = 3'd2;
   localparam logic [2:0] FUNC_SPHERE    = 3'd3;
   localparam logic [2:0] FUNC_OFFSET    = 3'd4;
   localparam logic [2:0] FUNC_ADD_BURN  = 3'd5;

   localparam logic [2:0] REG_INIT_X    = 3'd0;
   localparam logic [2:0] REG_INIT_Y    = 3'd1;
   localparam logic [2:0] REG_INIT_Z    = 3'd2;
   localparam logic [2:0] REG_PINNED    = 3'd3;
   localparam logic [2:0] REG_DAMPING   = 3'd4;
   localparam logic [2:0] REG_BURN_RATE = 3'd5;

   localparam logic [16:0] BURN_ONE       = 17'd65536;
   localparam logic [16:0] BURN_LIMIT     = 17'd58982;
   localparam logic [16:0] GROUND_DAMPING = 17'd6554;

   typedef enum logic [4:0] {
      S_IDLE, S_EXEC, S_T_BURN, S_T_CHK, S_T_DMG, S_V_MUL, S_V_ACC, S_V_UPD,
      S_SQ_MUL, S_SQ_ACC, S_R2_MUL, S_R2_CMP, S_SQRT, S_D_MUL, S_D_START,
      S_D_WAIT, S_RESP
   } state_type;

   // Command to the iterative root and divide unit.
   typedef struct packed {
      logic start;
      logic is_div;
      logic neg;
   } iter_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -50'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic [16:0] clamp_burn(input logic signed [49:0] v);
      if (v < 50'sd0) begin
         return 17'd0;
      end else if (v > 50'sd65536) begin
         return BURN_ONE;
      end else begin
         return v[16:0];
      end
   endfunction

endpackage

// File: rtl/core/verlet_particle_step.sv
// ---------------------------------------------------------------------------
// Verlet particle step
// One cloth particle in Q16.16: forces, damped Verlet tick with burning,
// ground and sphere collision, offset and burn, under a small sequencer.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   req_     in         tdata: vec_x,y,z, scalar, origin_x,y,z; tuser: func
//   rsp_     out        tdata: pos_x,y,z, on_ground, burn_level, damage
//   csr_     in         write enable, register index, 32 bit data
//
// One item at a time. A sphere collision runs the bit-serial square root
// and then the three 64-step divisions on the shared iterative unit.
// Reset is synchronous and active high and clears all particle state.
// A result waiting on rsp_tready does not block the next request transfer.
// ---------------------------------------------------------------------------
`include "verlet_particle_step_macros.svh"

module verlet_particle_step import vps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x [31:0], vec_y [63:32], vec_z [95:64], scalar [127:96],
   // origin_x [159:128], origin_y [191:160], origin_z [223:192]
   input  logic [223:0] req_tdata,
   // func [2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x [31:0], pos_y [63:32], pos_z [95:64], on_ground [96],
   // burn_level [113:97], damage_valid [114], damage_amount [145:115]
   output logic [151:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   state_type state_ff, state_in;

   // Particle state.
   logic signed [31:0] pos_ff [0:2], pos_in [0:2];
   logic signed [31:0] prior_ff [0:2], prior_in [0:2];
   logic signed [31:0] acc_ff [0:2], acc_in [0:2];
   logic [16:0] damp_ff, damp_in, burn_ff, burn_in;
   logic        ground_ff, ground_in, pinned_ff, pinned_in;
   logic [23:0] rate_ff, rate_in;

   // Latched request.
   logic [2:0]         func_ff, func_in;
   logic signed [31:0] vec_ff [0:2], vec_in [0:2];
   logic signed [31:0] org_ff [0:2], org_in [0:2];
   logic signed [31:0] scal_ff, scal_in;

   // Working registers.
   logic signed [31:0] d_ff [0:2], d_in [0:2];
   logic [63:0]        dist_ff, dist_in;
   logic signed [31:0] bd_ff, bd_in;
   logic signed [34:0] t_ff, t_in;
   logic               dmgv_ff, dmgv_in;
   logic [30:0]        dmg_ff, dmg_in;
   logic [1:0]         axis_ff, axis_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [151:0] rsp_data_ff, rsp_data_in;

   // Shared arithmetic.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p, prod_sh;
   iter_cmd_type       iter_cmd;
   logic [63:0]        iter_opa;
   logic signed [32:0] iter_quot;
   logic               iter_done;

   logic signed [17:0] burn_s, factor;
   logic signed [31:0] bd;

   vps_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   vps_iter u_iter (
      .clock(clock), .reset(reset), .cmd(iter_cmd), .opa(iter_opa),
      .quot(iter_quot), .done(iter_done)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Products are Q16.16 times Q16.16; an arithmetic shift rounds toward minus
   // infinity as the fixed-point scaling requires.
   assign prod_sh = mul_p >>> 16;
   assign burn_s  = signed'({1'b0, burn_ff});
   assign factor  = 18'sd65536 - signed'({1'b0, damp_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         damp_ff      <= 17'd0;
         burn_ff      <= 17'd0;
         ground_ff    <= 1'b0;
         pinned_ff    <= 1'b0;
         rate_ff      <= 24'd0;
         dmgv_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= 32'sd0;
            prior_ff[i] <= 32'sd0;
            acc_ff[i]   <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         damp_ff      <= damp_in;
         burn_ff      <= burn_in;
         ground_ff    <= ground_in;
         pinned_ff    <= pinned_in;
         rate_ff      <= rate_in;
         dmgv_ff      <= dmgv_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= pos_in[i];
            prior_ff[i] <= prior_in[i];
            acc_ff[i]   <= acc_in[i];
         end
      end
      func_ff     <= func_in;
      scal_ff     <= scal_in;
      dist_ff     <= dist_in;
      bd_ff       <= bd_in;
      t_ff        <= t_in;
      dmg_ff      <= dmg_in;
      axis_ff     <= axis_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         vec_ff[i] <= vec_in[i];
         org_ff[i] <= org_in[i];
         d_ff[i]   <= d_in[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      damp_in      = damp_ff;
      burn_in      = burn_ff;
      ground_in    = ground_ff;
      pinned_in    = pinned_ff;
      rate_in      = rate_ff;
      func_in      = func_ff;
      scal_in      = scal_ff;
      dist_in      = dist_ff;
      bd_in        = bd_ff;
      t_in         = t_ff;
      dmgv_in      = dmgv_ff;
      dmg_in       = dmg_ff;
      axis_in      = axis_ff;
      pos_in       = pos_ff;
      prior_in     = prior_ff;
      acc_in       = acc_ff;
      vec_in       = vec_ff;
      org_in       = org_ff;
      d_in         = d_ff;
      mul_a        = 34'sd0;
      mul_b        = 34'sd0;
      iter_cmd     = '0;
      iter_opa     = dist_ff;
      bd           = sat32(50'(prod_sh));

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               scal_in = req_tdata[127:96];
               for (int i = 0; i < 3; i++) begin
                  vec_in[i] = req_tdata[32*i +: 32];
                  org_in[i] = req_tdata[128 + 32*i +: 32];
               end
               dmgv_in  = 1'b0;
               dmg_in   = 31'd0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (func_ff)
               FUNC_ADD_FORCE: begin
                  if (!pinned_ff) begin
                     for (int i = 0; i < 3; i++) begin
                        acc_in[i] = sat32(50'(acc_ff[i]) + 50'(vec_ff[i]));
                     end
                  end
               end
               FUNC_TICK: begin
                  axis_in = 2'd0;
                  if (burn_ff != 17'd0) begin
                     mul_a    = signed'({10'd0, rate_ff});
                     mul_b    = 34'(scal_ff);
                     state_in = S_T_BURN;
                  end else begin
                     state_in = S_V_MUL;
                  end
               end
               FUNC_GROUND: begin
                  // Contact when the particle is at or below the ground plane.
                  if (pos_ff[2] <= scal_ff) begin
                     pos_in[2] = scal_ff;
                     if (acc_ff[2] <= 32'sd0) begin
                        acc_in[2] = 32'sd0;
                     end
                     damp_in   = GROUND_DAMPING;
                     ground_in = 1'b1;
                  end else begin
                     ground_in = 1'b0;
                  end
               end
               FUNC_SPHERE: begin
                  for (int i = 0; i < 3; i++) begin
                     d_in[i] = sat32(50'(pos_ff[i]) + 50'(org_ff[i]) - 50'(vec_ff[i]));
                  end
                  dist_in  = 64'd0;
                  axis_in  = 2'd0;
                  state_in = S_SQ_MUL;
               end
               FUNC_OFFSET: begin
                  for (int i = 0; i < 3; i++) begin
                     pos_in[i] = sat32(50'(pos_ff[i]) + 50'(vec_ff[i]));
                  end
               end
               FUNC_ADD_BURN: begin
                  burn_in = clamp_burn(50'(burn_s) + 50'(scal_ff));
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_T_BURN: begin
            // Burn growth this step, then the clamped new level.
            bd_in    = bd;
            burn_in  = clamp_burn(50'(burn_s) + 50'(bd));
            state_in = S_T_CHK;
         end
         S_T_CHK: begin
            if (burn_ff > BURN_LIMIT) begin
               mul_a    = 34'(bd_ff) + 34'(burn_s);
               mul_b    = 34'(scal_ff);
               state_in = S_T_DMG;
            end else begin
               state_in = S_V_MUL;
            end
         end
         S_T_DMG: begin
            dmgv_in = 1'b1;
            if (prod_sh < 68'sd0) begin
               dmg_in = 31'd0;
            end else if (prod_sh > 68'sd2147483647) begin
               dmg_in = 31'h7FFFFFFF;
            end else begin
               dmg_in = prod_sh[30:0];
            end
            state_in = S_V_MUL;
         end
         S_V_MUL: begin
            // A pinned particle skips the integration entirely.
            if (pinned_ff) begin
               state_in = S_RESP;
            end else begin
               mul_a    = 34'(pos_ff[axis_ff]) - 34'(prior_ff[axis_ff]);
               mul_b    = 34'(factor);
               state_in = S_V_ACC;
            end
         end
         S_V_ACC: begin
            t_in     = 35'(prod_sh);
            mul_a    = 34'(acc_ff[axis_ff]);
            mul_b    = 34'(scal_ff);
            state_in = S_V_UPD;
         end
         S_V_UPD: begin
            prior_in[axis_ff] = pos_ff[axis_ff];
            pos_in[axis_ff]   = sat32(50'(pos_ff[axis_ff]) + 50'(t_ff) + 50'(prod_sh));
            acc_in[axis_ff]   = 32'sd0;
            if (axis_ff == 2'd2) begin
               state_in = S_RESP;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_V_MUL;
            end
         end
         S_SQ_MUL: begin
            mul_a    = 34'(d_ff[axis_ff]);
            mul_b    = 34'(d_ff[axis_ff]);
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            dist_in = dist_ff + mul_p[63:0];
            if (axis_ff == 2'd2) begin
               state_in = S_R2_MUL;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_SQ_MUL;
            end
         end
         S_R2_MUL: begin
            mul_a    = 34'(scal_ff);
            mul_b    = 34'(scal_ff);
            state_in = S_R2_CMP;
         end
         S_R2_CMP: begin
            state_in = S_RESP;
            if (scal_ff > 32'sd0 && dist_ff < mul_p[63:0]) begin
               if (dist_ff == 64'd0) begin
                  // Particle sits on the centre: move it onto the centre itself.
                  for (int i = 0; i < 3; i++) begin
                     pos_in[i] = sat32(50'(vec_ff[i]) - 50'(org_ff[i]));
                  end
               end else begin
                  iter_cmd.start = 1'b1;
                  state_in       = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            axis_in = 2'd0;
            if (iter_done) begin
               state_in = S_D_MUL;
            end
         end
         S_D_MUL: begin
            mul_a    = 34'(d_ff[axis_ff]);
            mul_b    = 34'(scal_ff);
            state_in = S_D_START;
         end
         S_D_START: begin
            iter_cmd.start  = 1'b1;
            iter_cmd.is_div = 1'b1;
            iter_cmd.neg    = mul_p[63];
            iter_opa        = mul_p[63] ? 64'(-mul_p) : mul_p[63:0];
            state_in        = S_D_WAIT;
         end
         S_D_WAIT: begin
            if (iter_done) begin
               pos_in[axis_ff] = sat32(50'(vec_ff[axis_ff]) + 50'(iter_quot)
                                       - 50'(org_ff[axis_ff]));
               if (axis_ff == 2'd2) begin
                  state_in = S_RESP;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_D_MUL;
               end
            end
         end
         S_RESP: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, dmg_ff, dmgv_ff, burn_ff, ground_ff,
                               pos_ff[2], pos_ff[1], pos_ff[0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_we) begin
         case (csr_addr)
            REG_INIT_X, REG_INIT_Y, REG_INIT_Z: begin
               pos_in[csr_addr[1:0]]   = csr_wdata;
               prior_in[csr_addr[1:0]] = csr_wdata;
            end
            REG_PINNED: begin
               pinned_in = csr_wdata[0];
            end
            REG_DAMPING: begin
               damp_in = csr_wdata[16:0];
            end
            REG_BURN_RATE: begin
               rate_in = csr_wdata[23:0];
            end
            default: begin
               rate_in = rate_ff;
            end
         endcase
      end
   end

   `VPS_ASSERT_IMP(a_burn_range, clock, reset, 1'b1, burn_ff <= BURN_ONE)
   `VPS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `VPS_ASSERT_IMP(a_damage_burnt, clock, reset, dmgv_ff, burn_ff > BURN_LIMIT)
   `VPS_ASSERT_IMP(a_iter_expected, clock, reset, iter_done, state_ff == S_SQRT || state_ff == S_D_WAIT)
endmodule

// File: rtl/core/vps_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 34 by 34 bit product, registered once.
// ---------------------------------------------------------------------------
module vps_mul import vps_pkg::*; (
   input  logic               clock,
   input  logic signed [33:0] a,
   input  logic signed [33:0] b,
   output logic signed [67:0] p
);
   logic signed [67:0] p_ff;
   logic signed [67:0] p_in;

   assign p_in = a * b;
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule

// File: rtl/core/vps_iter.sv
// ---------------------------------------------------------------------------
// Iterative root and divide unit
// Floor square root of 64 bits in 32 steps, or a 64 by 32 bit division
// by the last root in 64 steps, truncated toward zero.
// ---------------------------------------------------------------------------
module vps_iter import vps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  iter_cmd_type       cmd,
   input  logic [63:0]        opa,
   output logic signed [32:0] quot,
   output logic               done
);
   logic        busy_ff, busy_in, done_ff, done_in, div_ff, div_in, neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] root_ff, root_in;
   logic [34:0] rem2, trial;
   logic [32:0] rem1;
   logic [5:0]  last;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      root_in = root_ff;
      rem2    = {r_ff, x_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      rem1    = {r_ff[31:0], x_ff[63]};
      last    = div_ff ? 6'd63 : 6'd31;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         neg_in  = cmd.neg;
         cnt_in  = 6'd0;
         x_in    = opa;
         r_in    = 33'd0;
         if (!cmd.is_div) begin
            root_in = 32'd0;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            if (rem1 >= {1'b0, root_ff}) begin
               r_in = rem1 - {1'b0, root_ff};
               x_in = {x_ff[62:0], 1'b1};
            end else begin
               r_in = rem1;
               x_in = {x_ff[62:0], 1'b0};
            end
         end else begin
            x_in = {x_ff[61:0], 2'b00};
            if (rem2 >= trial) begin
               r_in    = 33'(rem2 - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               r_in    = 33'(rem2);
               root_in = {root_ff[30:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -signed'({1'b0, x_ff[31:0]}) : signed'({1'b0, x_ff[31:0]});
endmodule

// File: tb/verlet_particle_step_test.sv
// ---------------------------------------------------------------------------
// Verlet particle step testbench
// Drives actions into the particle through req_, checks each rsp_ transfer
// against an in-bench Q16.16 predictor, and rewrites the registers between
// phases while the block is idle. Both sides idle at random per phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module verlet_particle_step_test;
   import vps_pkg::*;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] vx, vy, vz, scalar, ox, oy, oz;
   } action_type;

   typedef struct packed {
      logic signed [31:0] px, py, pz;
      logic               ground;
      logic [16:0]        burn;
      logic               dmg_valid;
      logic [30:0]        dmg;
   } status_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;

   verlet_particle_step u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_addr, .csr_wdata
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("verlet_particle_step regression: fail");
      $finish;
   end

   // Predicted particle state and register copies.
   logic signed [31:0] m_pos [3];
   logic signed [31:0] m_prior [3];
   logic signed [31:0] m_accel [3];
   logic [16:0]        m_damp;
   logic [16:0]        m_burn;
   logic               m_ground;
   logic               m_pinned;
   logic [23:0]        m_rate;

   action_type pending_actions[$];
   status_type expected_status[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Arithmetic shift right of a signed value is floor division by 2^16.
   function automatic logic signed [127:0] fx_mul(input logic signed [127:0] a,
                                                  input logic signed [127:0] b);
      logic signed [127:0] p;
      p = a * b;
      return p >>> 16;
   endfunction

   function automatic logic [16:0] burn_clamp(input logic signed [127:0] v);
      if (v < 0) return 17'd0;
      if (v > 128'sd65536) return BURN_ONE;
      return v[16:0];
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic status_type step_particle(input action_type a);
      status_type r;
      logic signed [127:0] vec [3], org [3], d [3], sc, bd, dmg, fac, np, len;
      logic [127:0] dist2, mag;
      r = '0;
      vec[0] = a.vx; vec[1] = a.vy; vec[2] = a.vz;
      org[0] = a.ox; org[1] = a.oy; org[2] = a.oz;
      sc = a.scalar;
      case (a.func)
         FUNC_ADD_FORCE: begin
            if (!m_pinned)
               for (int i = 0; i < 3; i++)
                  m_accel[i] = clip32(128'(m_accel[i]) + vec[i]);
         end
         FUNC_TICK: begin
            if (m_burn > 0) begin
               bd = clip32(fx_mul($signed({1'b0, m_rate}), sc));
               m_burn = burn_clamp($signed({1'b0, m_burn}) + bd);
               if (m_burn > BURN_LIMIT) begin
                  r.dmg_valid = 1'b1;
                  dmg = fx_mul(bd + $signed({1'b0, m_burn}), sc);
                  if (dmg < 0) dmg = 0;
                  if (dmg > 128'sd2147483647) dmg = 128'sd2147483647;
                  r.dmg = dmg[30:0];
               end
            end
            if (!m_pinned) begin
               fac = 128'sd65536 - $signed({1'b0, m_damp});
               for (int i = 0; i < 3; i++) begin
                  np = 128'(m_pos[i]) + fx_mul(128'(m_pos[i]) - m_prior[i], fac)
                     + fx_mul(m_accel[i], sc);
                  m_prior[i] = m_pos[i];
                  m_pos[i] = clip32(np);
                  m_accel[i] = 0;
               end
            end
         end
         FUNC_GROUND: begin
            if (128'(m_pos[2]) <= sc) begin
               m_pos[2] = a.scalar;
               if (m_accel[2] <= 0) m_accel[2] = 0;
               m_damp = GROUND_DAMPING;
               m_ground = 1'b1;
            end else begin
               m_ground = 1'b0;
            end
         end
         FUNC_SPHERE: begin
            dist2 = 0;
            for (int i = 0; i < 3; i++) begin
               d[i] = clip32(128'(m_pos[i]) + org[i] - vec[i]);
               mag = d[i] < 0 ? -d[i] : d[i];
               dist2 += mag * mag;
            end
            if (sc > 0 && dist2 < 128'(sc * sc)) begin
               if (dist2 == 0) begin
                  for (int i = 0; i < 3; i++) m_pos[i] = clip32(vec[i] - org[i]);
               end else begin
                  len = $signed({64'd0, root64(dist2[63:0])});
                  for (int i = 0; i < 3; i++)
                     m_pos[i] = clip32(vec[i] + (d[i] * sc) / len - org[i]);
               end
            end
         end
         FUNC_OFFSET: begin
            for (int i = 0; i < 3; i++) m_pos[i] = clip32(128'(m_pos[i]) + vec[i]);
         end
         FUNC_ADD_BURN: m_burn = burn_clamp($signed({1'b0, m_burn}) + sc);
         default: ;
      endcase
      r.px = m_pos[0]; r.py = m_pos[1]; r.pz = m_pos[2];
      r.ground = m_ground;
      r.burn = m_burn;
      return r;
   endfunction

   // Driver: one request transfer at a time from the pending queue.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_actions.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               action_type a;
               a = pending_actions.pop_front();
               expected_status.push_back(step_particle(a));
               req_tvalid <= 1'b1;
               req_tuser <= a.func;
               req_tdata <= {a.oz, a.oy, a.ox, a.scalar, a.vz, a.vy, a.vx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every result transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            status_type got, exp_s;
            got = '0;
            got.px = rsp_tdata[31:0];
            got.py = rsp_tdata[63:32];
            got.pz = rsp_tdata[95:64];
            got.ground = rsp_tdata[96];
            got.burn = rsp_tdata[113:97];
            got.dmg_valid = rsp_tdata[114];
            got.dmg = rsp_tdata[145:115];
            if (expected_status.size() == 0) begin
               errors++;
               $display("%0t unexpected result %h", $realtime, got);
            end else begin
               exp_s = expected_status.pop_front();
               if (got.px !== exp_s.px) begin
                  errors++;
                  $display("%0t pos_x exp %h got %h", $realtime, exp_s.px, got.px);
               end
               if (got.py !== exp_s.py) begin
                  errors++;
                  $display("%0t pos_y exp %h got %h", $realtime, exp_s.py, got.py);
               end
               if (got.pz !== exp_s.pz) begin
                  errors++;
                  $display("%0t pos_z exp %h got %h", $realtime, exp_s.pz, got.pz);
               end
               if (got.ground !== exp_s.ground) begin
                  errors++;
                  $display("%0t on_ground exp %b got %b", $realtime, exp_s.ground,
                           got.ground);
               end
               if (got.burn !== exp_s.burn) begin
                  errors++;
                  $display("%0t burn exp %h got %h", $realtime, exp_s.burn, got.burn);
               end
               if (got.dmg_valid !== exp_s.dmg_valid) begin
                  errors++;
                  $display("%0t damage_valid exp %b got %b", $realtime,
                           exp_s.dmg_valid, got.dmg_valid);
               end
               if (got.dmg !== exp_s.dmg) begin
                  errors++;
                  $display("%0t damage exp %h got %h", $realtime, exp_s.dmg, got.dmg);
               end
            end
         end
      end
   end

   function automatic logic [31:0] any_word();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(32'h30000) - 32'h18000;
         default: return $urandom;
      endcase
   endfunction

   // Positions within plus or minus 128 units keep the sphere tests reachable.
   function automatic logic [31:0] near_word();
      return $urandom_range(32'h01000000) - 32'h00800000;
   endfunction

   task automatic queue_action(input logic [2:0] f, input logic [31:0] x, y, z, s,
                               input logic [31:0] ox, oy, oz);
      action_type a;
      a.func = f; a.vx = x; a.vy = y; a.vz = z; a.scalar = s;
      a.ox = ox; a.oy = oy; a.oz = oz;
      pending_actions.push_back(a);
   endtask

   // A register write happens only with nothing in flight.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_INIT_X: begin m_pos[0] = value; m_prior[0] = value; end
         REG_INIT_Y: begin m_pos[1] = value; m_prior[1] = value; end
         REG_INIT_Z: begin m_pos[2] = value; m_prior[2] = value; end
         REG_PINNED: m_pinned = value[0];
         REG_DAMPING: m_damp = value[16:0];
         REG_BURN_RATE: m_rate = value[23:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_actions.size() > 0 || expected_status.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_actions(input int count);
      logic [2:0] f;
      logic [31:0] s;
      for (int n = 0; n < count; n++) begin
         f = $urandom_range(99) < 3 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
         case (f)
            FUNC_TICK: s = $urandom_range(9) == 0 ? any_word() : $urandom_range(32'h20000);
            FUNC_SPHERE: s = $urandom_range(9) == 0 ? any_word()
                                                    : $urandom_range(32'h02000000);
            FUNC_ADD_BURN: s = $urandom_range(3) == 0 ? any_word()
                                                      : $urandom_range(32'h20000) - 32'h8000;
            default: s = $urandom_range(1) ? near_word() : any_word();
         endcase
         if ($urandom_range(3) == 0)
            queue_action(f, any_word(), any_word(), any_word(), s,
                         any_word(), any_word(), any_word());
         else
            queue_action(f, near_word(), near_word(), near_word(), s,
                         near_word() >>> 4, near_word() >>> 4, near_word() >>> 4);
      end
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         m_pos[i] = 0; m_prior[i] = 0; m_accel[i] = 0;
      end
      m_damp = 0; m_burn = 0; m_ground = 0; m_pinned = 0; m_rate = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every action, field extremes, zero direction sphere.
      send_idle_pct = 9;
      recv_idle_pct = 58;
      csr_write(REG_INIT_X, 32'h00010000);
      csr_write(REG_INIT_Y, 32'hFFFF0000);
      csr_write(REG_INIT_Z, 32'h00050000);
      csr_write(REG_DAMPING, 32'd1000);
      csr_write(REG_BURN_RATE, 32'h00FFFFFF);
      queue_action(FUNC_ADD_FORCE, 32'h7FFFFFFF, 32'h80000000, 32'hFFF00000, 0, 0, 0, 0);
      queue_action(FUNC_ADD_FORCE, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0);
      queue_action(FUNC_TICK, 0, 0, 0, 32'h00000400, 0, 0, 0);
      queue_action(FUNC_GROUND, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0);
      queue_action(FUNC_GROUND, 0, 0, 0, 32'h80000000, 0, 0, 0);
      queue_action(FUNC_ADD_BURN, 0, 0, 0, 32'h0000E000, 0, 0, 0);
      queue_action(FUNC_TICK, 0, 0, 0, 32'h00010000, 0, 0, 0);
      queue_action(FUNC_TICK, 0, 0, 0, 32'h80000000, 0, 0, 0);
      queue_action(FUNC_ADD_BURN, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0);
      queue_action(FUNC_TICK, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0);
      queue_action(FUNC_ADD_BURN, 0, 0, 0, 32'h80000000, 0, 0, 0);
      queue_action(FUNC_OFFSET, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0, 0, 0, 0);
      queue_action(FUNC_OFFSET, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
      queue_action(FUNC_SPHERE, 32'h00010000, 32'h00020000, 32'h00030000,
                   32'h00100000, 0, 0, 0);
      queue_action(FUNC_SPHERE, 32'h00018000, 32'h00020000, 32'h00030000,
                   32'h00100000, 32'h00010000, 0, 0);
      queue_action(FUNC_SPHERE, 0, 0, 0, 32'h80000000, 0, 0, 0);
      queue_action(FUNC_SPHERE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_action(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_action(3'd7, 0, 0, 0, 0, 0, 0, 0);
      drain();

      // Pinned particle, damping above one.
      csr_write(REG_PINNED, 32'd1);
      csr_write(REG_DAMPING, 32'h0001FFFF);
      queue_action(FUNC_ADD_FORCE, 32'h00010000, 0, 0, 0, 0, 0, 0);
      queue_action(FUNC_TICK, 0, 0, 0, 32'h00010000, 0, 0, 0);
      drain();
      csr_write(REG_PINNED, 32'd0);
      queue_action(FUNC_OFFSET, 32'h00030000, 0, 0, 0, 0, 0, 0);
      queue_action(FUNC_TICK, 0, 0, 0, 32'h00010000, 0, 0, 0);
      random_actions(160);
      drain();

      // Second phase: receiver eager, sender idles often.
      send_idle_pct = 58;
      recv_idle_pct = 9;
      csr_write(REG_INIT_X, 32'h80000000);
      csr_write(REG_INIT_Y, 32'h7FFFFFFF);
      csr_write(REG_INIT_Z, 32'd0);
      csr_write(REG_DAMPING, 32'd65536);
      csr_write(REG_BURN_RATE, 32'd0);
      random_actions(180);
      drain();

      // Third phase: no idling, mid settings.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_INIT_X, near_word());
      csr_write(REG_INIT_Y, near_word());
      csr_write(REG_INIT_Z, near_word());
      csr_write(REG_DAMPING, 32'd0);
      csr_write(REG_BURN_RATE, 32'h00008000);
      random_actions(180);
      drain();

      if (errors == 0) begin
         $display("verlet_particle_step regression: pass");
      end else begin
         $display("verlet_particle_step regression: fail");
      end
      $finish;
   end

endmodule
